// ===== hdl/dfq_pkg.sv =====
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared codes and types of the de-duplicating FIFO queue: command and
// status codes and the result word passed from the sequencer to the top.
// ----------------------------------------------------------------------------
`default_nettype none

package dfq_pkg;

  // Fixed field widths of the channels
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int FIELD_W  = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENQ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LIST  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LISTF = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SERVED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LISTED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DISCARD = 3'd6;

  // One result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  value;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/dedup_fifo_queue_top.sv =====
// ----------------------------------------------------------------------------
// dedup_fifo_queue_top
// FIFO queue of IDs that refuses duplicates, with list and flush commands.
//
// Input channel (in_valid / in_stall): one word per request, in_cmd and
// in_item_id. The block takes one request at a time; in_stall is high
// from acceptance until the last result of that request has left the
// sequencer. Unknown commands are taken and dropped.
// Result channel (out_valid / out_stall): out_status, out_item_value and
// out_last; out_last marks the final word of each request.
// An enqueue walks the waiting IDs through the single slot read port, one
// compare per cycle, and loads its result word from the response state.
// Dequeue, flush and empty cases load their word from the serve or
// response state. A list loads one word per cycle while the receiver does
// not stall. The next request is taken once the sequencer is back in idle,
// which it enters as the last word loads.
// Reset clears pointers and fill count; the queue is empty afterwards and
// slot contents are left as they are. A stalled receiver holds the output
// register and, through it, the sequencer; no word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_fifo_queue_top import dfq_pkg::*; #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [FIELD_W-1:0] in_item_id,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [FIELD_W-1:0] out_item_value,
  output logic                    out_last
);

  localparam int SW = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          busy;
  logic          res_valid;
  res_t          res;
  logic          res_stall;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  logic [SW-1:0] mem_rdata;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_r;
  logic          load;

  dfq_ctrl #(
    .DEPTH (DEPTH),
    .SW    (SW),
    .PW    (PW),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_item_id (in_item_id),
    .busy       (busy),
    .res_valid  (res_valid),
    .res        (res),
    .res_stall  (res_stall),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  dfq_mem #(
    .DEPTH (DEPTH),
    .W     (SW),
    .PW    (PW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_stall     = out_valid_r && out_stall;
  assign load          = res_valid && !res_stall;
  assign out_valid_nxt = load || res_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign in_stall       = busy;
  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_item_value = out_r.value;
  assign out_last       = out_r.last;

endmodule

`default_nettype wire

// ===== hdl/dfq_mem.sv =====
// ----------------------------------------------------------------------------
// dfq_mem
// Slot storage of the queue: one write port, one read port with a
// registered read word that holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module dfq_mem #(
  parameter int DEPTH = 16,
  parameter int W     = 16,
  parameter int PW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [PW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [PW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // Write one slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one slot, hold the word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/dfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfq_ctrl
// Sequencer of the queue: keeps the pointers and fill count, walks the
// slots through the single read port with one shared comparator for the
// duplicate search, and streams served or listed words.
// ----------------------------------------------------------------------------
`default_nettype none

module dfq_ctrl import dfq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int SW    = 16,
  parameter int PW    = 4,
  parameter int CW    = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [FIELD_W-1:0] in_item_id,
  output logic                    busy,
  output logic                    res_valid,
  output res_t                    res,
  input  wire logic               res_stall,
  output logic                    mem_we,
  output logic      [PW-1:0]      mem_waddr,
  output logic      [SW-1:0]      mem_wdata,
  output logic                    mem_re,
  output logic      [PW-1:0]      mem_raddr,
  input  wire logic [SW-1:0]      mem_rdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_LIST  = 5'b00100,
    S_SERVE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [PW-1:0]      head_r, head_nxt;
  logic [PW-1:0]      tail_r, tail_nxt;
  logic [PW-1:0]      walk_r, walk_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]      id_r, id_nxt;
  logic               flush_r, flush_nxt;
  logic               pend_r, pend_nxt;
  logic [STATUS_W-1:0] rstat_r, rstat_nxt;
  logic               hit;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Shared comparator: the word read last cycle against the ID on hand
  assign hit = pend_r && (mem_rdata == id_r);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    walk_nxt  = walk_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    id_nxt    = id_r;
    flush_nxt = flush_r;
    pend_nxt  = pend_r;
    rstat_nxt = rstat_r;
    mem_we    = 1'b0;
    mem_waddr = tail_r;
    mem_wdata = id_r;
    mem_re    = 1'b0;
    mem_raddr = walk_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt = in_item_id[SW-1:0];
          unique case (in_cmd)
            CMD_ENQ: begin
              // start the duplicate search at the oldest slot
              cnt_nxt   = '0;
              walk_nxt  = head_r;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
            CMD_DEQ: begin
              if (fill_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = S_SERVE;
              end
            end
            CMD_LIST, CMD_LISTF: begin
              flush_nxt = (in_cmd == CMD_LISTF);
              if (fill_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_RESP;
                if (in_cmd == CMD_LISTF) begin
                  head_nxt = '0;
                  tail_nxt = '0;
                end
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                walk_nxt  = wrap_inc(head_r);
                cnt_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            CMD_FLUSH: begin
              rstat_nxt = (fill_r != '0) ? ST_DISCARD : ST_OK;
              head_nxt  = '0;
              tail_nxt  = '0;
              fill_nxt  = '0;
              state_nxt = S_RESP;
            end
            default: ;  // unknown command: drop
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          rstat_nxt = ST_DUP;
          state_nxt = S_RESP;
        end else if ((cnt_r == fill_r) && !pend_r) begin
          // search done without a match
          if (fill_r == CW'(DEPTH)) begin
            rstat_nxt = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            tail_nxt  = wrap_inc(tail_r);
            fill_nxt  = fill_r + CW'(1);
            rstat_nxt = ST_OK;
          end
          state_nxt = S_RESP;
        end else begin
          // issue the next read while the previous word is compared
          pend_nxt = (cnt_r != fill_r);
          if (cnt_r != fill_r) begin
            mem_re   = 1'b1;
            walk_nxt = wrap_inc(walk_r);
            cnt_nxt  = cnt_r + CW'(1);
          end
        end
      end

      S_LIST: begin
        if (!res_stall) begin
          if (cnt_r == fill_r - CW'(1)) begin
            if (flush_r) begin
              head_nxt = '0;
              tail_nxt = '0;
              fill_nxt = '0;
            end
            state_nxt = S_IDLE;
          end else begin
            mem_re   = 1'b1;
            walk_nxt = wrap_inc(walk_r);
            cnt_nxt  = cnt_r + CW'(1);
          end
        end
      end

      S_SERVE: begin
        if (!res_stall) begin
          head_nxt  = wrap_inc(head_r);
          fill_nxt  = fill_r - CW'(1);
          state_nxt = S_IDLE;
        end
      end

      S_RESP: begin
        if (!res_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    walk_r  <= walk_nxt;
    cnt_r   <= cnt_nxt;
    id_r    <= id_nxt;
    flush_r <= flush_nxt;
    rstat_r <= rstat_nxt;
  end

  // Result word toward the output register
  always_comb begin
    res_valid  = 1'b0;
    res.status = rstat_r;
    res.value  = '0;
    res.last   = 1'b1;
    unique case (state_r)
      S_LIST: begin
        res_valid  = 1'b1;
        res.status = ST_LISTED;
        res.value  = FIELD_W'(mem_rdata);
        res.last   = (cnt_r == fill_r - CW'(1));
      end
      S_SERVE: begin
        res_valid  = 1'b1;
        res.status = ST_SERVED;
        res.value  = FIELD_W'(mem_rdata);
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire
